@@ rtl/fen_record_parser_defines.svh @@
// assertion macros for the fen record parser
`ifndef FEN_RECORD_PARSER_DEFINES_SVH
`define FEN_RECORD_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define FRP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FRP_ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FRP_ASSERT(label, clk, rst_n, prop, msg)
`define FRP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ rtl/frp_pkg.sv @@
// shared types and constants of the fen record parser
package frp_pkg;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_8     = 8'h38;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_W     = 8'h77;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_UW    = 8'h57;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_UK    = 8'h4b;
	localparam logic [7:0] CH_UQ    = 8'h51;
	localparam logic [7:0] CH_K     = 8'h6b;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_N     = 8'h6e;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [6:0] EP_NONE  = 7'd64;
	localparam logic [16:0] CLOCK_SAT = 17'd65535;

	typedef enum logic [2:0] {
		TERM_PLACE = 3'd0, TERM_TURN = 3'd1, TERM_CASTLE = 3'd2,
		TERM_EP = 3'd3, TERM_HALF = 3'd4, TERM_FULL = 3'd5, TERM_DONE = 3'd6
	} term_t;

	typedef enum logic [4:0] {
		ERR_NONE = 5'd0, ERR_NO_POS = 5'd1, ERR_RANK_LONG = 5'd2,
		ERR_PIECE = 5'd3, ERR_RANKS = 5'd4, ERR_BOARD = 5'd5,
		ERR_NO_TURN = 5'd6, ERR_TURN_UPPER = 5'd7, ERR_TURN_CHAR = 5'd8,
		ERR_TURN_LONG = 5'd9, ERR_NO_CASTLE = 5'd10, ERR_K_TWICE = 5'd11,
		ERR_K_LATE = 5'd12, ERR_Q_TWICE = 5'd13, ERR_Q_LATE = 5'd14,
		ERR_LK_TWICE = 5'd15, ERR_LK_LATE = 5'd16, ERR_LQ_TWICE = 5'd17,
		ERR_CASTLE_CHAR = 5'd18, ERR_CASTLE_LONG = 5'd19, ERR_NO_EP = 5'd20,
		ERR_EP = 5'd21, ERR_NO_CLOCK = 5'd22, ERR_CLOCK_CHAR = 5'd23,
		ERR_CLOCK_BIG = 5'd24, ERR_TERMS = 5'd25
	} err_t;

	typedef struct packed {
		logic [63:0] pawns;
		logic [63:0] knights;
		logic [63:0] bishops;
		logic [63:0] rooks;
		logic [63:0] queens;
		logic [63:0] kings;
		logic [63:0] white_men;
		logic [63:0] black_men;
		logic [11:0] side_info;
		logic [31:0] move_clocks;
		logic [4:0]  status;
	} result_t;

	typedef struct packed {
		logic [7:0] ch;
	} item_t;

	function automatic err_t missing_code(input term_t t);
		unique case (t)
			TERM_PLACE:  missing_code = ERR_NO_POS;
			TERM_TURN:   missing_code = ERR_NO_TURN;
			TERM_CASTLE: missing_code = ERR_NO_CASTLE;
			TERM_EP:     missing_code = ERR_NO_EP;
			default:     missing_code = ERR_NO_CLOCK;
		endcase
	endfunction
endpackage

@@ rtl/frp_if.sv @@
// valid/ready stream interfaces for input bytes and results
interface frp_in_if;
	import frp_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface frp_out_if;
	import frp_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/fen_record_parser.sv @@
// top level of the fen record parser
// Takes one FEN byte per cycle on byte_in and, when the terminating zero byte
// is taken, presents one result word on res_out.
// Results go through a two-entry buffer, so bytes keep flowing while a result
// waits; byte_in stalls only on a terminator when that buffer is full.
module fen_record_parser (
	input  logic     clk,
	input  logic     arst_n,
	frp_in_if.sink   byte_in,
	frp_out_if.source res_out
);
	import frp_pkg::*;

	logic    acc;
	logic    res_vld;
	logic    full;
	result_t res;

	assign byte_in.ready = !full || byte_in.data.ch != CH_NUL;
	assign acc = byte_in.valid && byte_in.ready;

	frp_core u_core (
		.clk(clk), .arst_n(arst_n), .byte_vld(acc), .ch(byte_in.data.ch),
		.res_vld(res_vld), .res(res)
	);

	frp_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .wr(res_vld), .wdata(res), .full(full),
		.res_o(res_out)
	);
endmodule

@@ rtl/frp_core.sv @@
// parser state and per-byte update
module frp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_vld,
	input  logic [7:0]        ch,
	output logic              res_vld,
	output frp_pkg::result_t  res
);
	import frp_pkg::*;
	`include "fen_record_parser_defines.svh"

	term_t       term_q;
	logic [2:0]  tlen_q;
	logic        betw_q;
	logic [3:0]  rank_q;
	logic [4:0]  file_q;
	logic [6:0]  sqi_q;
	logic [63:0] bb_q [8];
	logic        black_q;
	logic [3:0]  cbits_q;
	logic [2:0]  cord_q;
	logic [7:0]  first_q;
	logic [6:0]  ep_q;
	logic [16:0] clk_q;
	logic [15:0] half_q;
	err_t        err_q;

	term_t       term_d;
	logic [2:0]  tlen_d;
	logic        betw_d;
	logic [3:0]  rank_d;
	logic [4:0]  file_d;
	logic [6:0]  sqi_d;
	logic [63:0] bb_d [8];
	logic        black_d;
	logic [3:0]  cbits_d;
	logic [2:0]  cord_d;
	logic [7:0]  first_d;
	logic [6:0]  ep_d;
	logic [16:0] clk_d;
	logic [15:0] half_d;
	err_t        err_d;
	logic        fin;

	// helpers
	logic [2:0]  p;
	logic [5:0]  idx;
	logic [5:0]  sq;
	logic [63:0] bit_m;
	logic        upper;
	logic [7:0]  low;
	logic [4:0]  fnew;
	logic [20:0] clk_mul;
	logic [3:0]  dig;

	always_comb begin
		term_d = term_q; tlen_d = tlen_q; betw_d = betw_q; rank_d = rank_q;
		file_d = file_q; sqi_d = sqi_q; bb_d = bb_q; black_d = black_q;
		cbits_d = cbits_q; cord_d = cord_q; first_d = first_q; ep_d = ep_q;
		clk_d = clk_q; half_d = half_q; err_d = err_q; fin = 1'b0;
		p = tlen_q;
		idx = sqi_q[5:0];
		sq = {~idx[5:3], idx[2:0]};
		bit_m = 64'd1 << sq;
		upper = (ch >= CH_UA) && (ch <= CH_UZ);
		low = upper ? ch + 8'd32 : ch;
		fnew = '0;
		dig = ch[3:0] - CH_0[3:0];
		clk_mul = {clk_q, 3'b000} + {3'b000, clk_q, 1'b0} + {17'd0, dig};
		if (byte_vld) begin
			if (ch == CH_NUL) begin
				fin = 1'b1;
			end else if (err_q != ERR_NONE) begin
			end else if (ch == CH_SP) begin
				if (!betw_q) begin
					fin = 1'b0;
				end
			end else if (betw_q && term_q == TERM_DONE) begin
				betw_d = 1'b0; tlen_d = '0; err_d = ERR_TERMS;
			end else begin
				if (betw_q) begin
					p = '0;
				end
				betw_d = 1'b0;
				tlen_d = (p < 3'd7) ? p + 3'd1 : p;
				if (p == 3'd0) first_d = ch;
				case (term_q)
					TERM_PLACE: begin
						if (file_q == 5'd8) begin
							if (ch != CH_SLASH) err_d = ERR_RANK_LONG;
							else begin
								file_d = '0; rank_d = rank_q + 4'd1;
								if (rank_q + 4'd1 > 4'd7) err_d = ERR_RANKS;
							end
						end else if (ch >= CH_0 && ch < CH_9) begin
							fnew = file_q + {1'b0, dig};
							file_d = fnew;
							sqi_d = sqi_q + {3'b000, dig};
							if (fnew > 5'd8) err_d = ERR_RANK_LONG;
							else if (rank_q > 4'd7) err_d = ERR_RANKS;
						end else if (low == CH_P || low == CH_N || low == CH_B ||
						             low == CH_R || low == CH_Q || low == CH_K) begin
							case (low)
								CH_P:    bb_d[0] = bb_q[0] | bit_m;
								CH_N:    bb_d[1] = bb_q[1] | bit_m;
								CH_B:    bb_d[2] = bb_q[2] | bit_m;
								CH_R:    bb_d[3] = bb_q[3] | bit_m;
								CH_Q:    bb_d[4] = bb_q[4] | bit_m;
								default: bb_d[5] = bb_q[5] | bit_m;
							endcase
							if (upper) bb_d[6] = bb_q[6] | bit_m;
							else bb_d[7] = bb_q[7] | bit_m;
							fnew = file_q + 5'd1;
							file_d = fnew;
							sqi_d = sqi_q + 7'd1;
							if (fnew > 5'd8) err_d = ERR_RANK_LONG;
							else if (rank_q > 4'd7) err_d = ERR_RANKS;
						end else begin
							err_d = ERR_PIECE;
						end
					end
					TERM_CASTLE: begin
						if (p >= 3'd4) err_d = ERR_CASTLE_LONG;
						else if (p == 3'd0 && ch == CH_DASH) begin
						end else if (p == 3'd1 && first_q == CH_DASH) err_d = ERR_CASTLE_CHAR;
						else if (ch == CH_UK) begin
							if (cord_q == 3'd1) err_d = ERR_K_TWICE;
							else if (cord_q > 3'd1) err_d = ERR_K_LATE;
							else begin cbits_d[0] = 1'b1; cord_d = 3'd1; end
						end else if (ch == CH_UQ) begin
							if (cord_q == 3'd2) err_d = ERR_Q_TWICE;
							else if (cord_q > 3'd2) err_d = ERR_Q_LATE;
							else begin cbits_d[1] = 1'b1; cord_d = 3'd2; end
						end else if (ch == CH_K) begin
							if (cord_q == 3'd3) err_d = ERR_LK_TWICE;
							else if (cord_q > 3'd3) err_d = ERR_LK_LATE;
							else begin cbits_d[2] = 1'b1; cord_d = 3'd3; end
						end else if (ch == CH_Q) begin
							if (cord_q == 3'd4) err_d = ERR_LQ_TWICE;
							else begin cbits_d[3] = 1'b1; cord_d = 3'd4; end
						end else err_d = ERR_CASTLE_CHAR;
					end
					TERM_EP: begin
						if (p == 3'd1) begin
							if (first_q >= CH_A && first_q <= CH_H && ch >= CH_1 && ch <= CH_8)
								ep_d = {1'b0, ch[2:0] - CH_1[2:0], first_q[2:0] - CH_A[2:0]};
							else err_d = ERR_EP;
						end else if (p >= 3'd2) err_d = ERR_EP;
					end
					TERM_HALF, TERM_FULL: begin
						if (ch < CH_0 || ch > CH_9) err_d = ERR_CLOCK_CHAR;
						else if (clk_mul > {4'd0, CLOCK_SAT}) clk_d = CLOCK_SAT;
						else clk_d = clk_mul[16:0];
					end
					default: begin
					end
				endcase
			end
		end
		// term end: on a space closing a term, or at the terminator
		if (byte_vld && !betw_q && err_q == ERR_NONE &&
		    (ch == CH_SP || ch == CH_NUL)) begin
			case (term_q)
				TERM_PLACE: if (rank_q < 4'd7 || file_q < 5'd8) err_d = ERR_BOARD;
				TERM_TURN: begin
					if (tlen_q > 3'd1) err_d = ERR_TURN_LONG;
					else if (first_q == CH_W) black_d = 1'b0;
					else if (first_q == CH_B) black_d = 1'b1;
					else if (first_q == CH_UB || first_q == CH_UW) err_d = ERR_TURN_UPPER;
					else err_d = ERR_TURN_CHAR;
				end
				TERM_EP: if (tlen_q == 3'd1) begin
					if (first_q == CH_DASH) ep_d = EP_NONE;
					else err_d = ERR_EP;
				end
				TERM_HALF, TERM_FULL: begin
					if (clk_q >= CLOCK_SAT) err_d = ERR_CLOCK_BIG;
					else if (term_q == TERM_HALF) begin
						half_d = clk_q[15:0]; clk_d = '0;
					end
				end
				default: begin
				end
			endcase
			if (term_q != TERM_DONE) term_d = term_t'(term_q + 3'd1);
			betw_d = 1'b1;
		end
		if (fin && err_d == ERR_NONE && term_d != TERM_DONE) err_d = missing_code(term_d);
	end

	always_comb begin
		res.status = err_d;
		if (err_d != ERR_NONE) begin
			res.pawns = '0; res.knights = '0; res.bishops = '0; res.rooks = '0;
			res.queens = '0; res.kings = '0; res.white_men = '0; res.black_men = '0;
			res.side_info = '0; res.move_clocks = '0;
		end else begin
			res.pawns = bb_d[0]; res.knights = bb_d[1]; res.bishops = bb_d[2];
			res.rooks = bb_d[3]; res.queens = bb_d[4]; res.kings = bb_d[5];
			res.white_men = bb_d[6]; res.black_men = bb_d[7];
			res.side_info = {ep_d, cbits_d, black_d};
			res.move_clocks = {clk_d[15:0], half_d};
		end
		res_vld = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= TERM_PLACE; tlen_q <= '0; betw_q <= 1'b1; rank_q <= '0;
			file_q <= '0; sqi_q <= '0; black_q <= 1'b0; cbits_q <= '0;
			cord_q <= '0; first_q <= '0; ep_q <= EP_NONE; clk_q <= '0;
			half_q <= '0; err_q <= ERR_NONE;
			for (int i = 0; i < 8; i++) bb_q[i] <= '0;
		end else if (fin) begin
			term_q <= TERM_PLACE; tlen_q <= '0; betw_q <= 1'b1; rank_q <= '0;
			file_q <= '0; sqi_q <= '0; black_q <= 1'b0; cbits_q <= '0;
			cord_q <= '0; first_q <= '0; ep_q <= EP_NONE; clk_q <= '0;
			half_q <= '0; err_q <= ERR_NONE;
			for (int i = 0; i < 8; i++) bb_q[i] <= '0;
		end else begin
			term_q <= term_d; tlen_q <= tlen_d; betw_q <= betw_d; rank_q <= rank_d;
			file_q <= file_d; sqi_q <= sqi_d; black_q <= black_d; cbits_q <= cbits_d;
			cord_q <= cord_d; first_q <= first_d; ep_q <= ep_d; clk_q <= clk_d;
			half_q <= half_d; err_q <= err_d;
			bb_q <= bb_d;
		end
	end

	`FRP_ASSERT(a_err_sticky, clk, arst_n,
		(err_q != ERR_NONE && !(byte_vld && ch == CH_NUL)) |=> $stable(err_q),
		"latched error changed before terminator")
	`FRP_ASSERT(a_colors_disjoint, clk, arst_n, (bb_q[6] & bb_q[7]) == 64'd0 ||
		err_q != ERR_NONE, "square holds both colors without error")
	`FRP_ASSERT(a_clock_sat, clk, arst_n, clk_q <= CLOCK_SAT, "clock beyond saturation")
endmodule

@@ rtl/frp_out_reg.sv @@
// two-entry output buffer between parser and result channel
module frp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  frp_pkg::result_t wdata,
	output logic             full,
	frp_out_if.source        res_o
);
	import frp_pkg::*;
	`include "fen_record_parser_defines.svh"

	result_t    mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign rd = res_o.valid && res_o.ready;
	assign res_o.valid = cnt_q != 2'd0;
	assign res_o.data = mem_q[rp_q];
	assign full = cnt_q == 2'd2;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	`FRP_ASSERT(a_no_overflow, clk, arst_n, !(wr && full && !rd), "result buffer overflow")
	`FRP_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= 2'd2, "result count out of range")
endmodule

@@ tb/frp_checker.sv @@
// predicts fen parser results from accepted bytes and compares them with the result words
module frp_checker (
	input  logic  clk,
	input  logic  arst_n,
	frp_in_if     in_ch,
	frp_out_if    out_ch,
	output int    errors,
	output int    pending
);
	import frp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	result_t      want_q[$];

	term_t        term_at;
	logic [2:0]   term_len;
	bit           gap_open;
	int           rank_n;
	int           file_n;
	int           sq_n;
	logic [63:0]  boards[8];
	bit           black;
	logic [3:0]   castle;
	int           castle_seen;
	logic [7:0]   lead_ch;
	logic [6:0]   ep_sq;
	int           clk_val;
	int           half_val;
	err_t         err;

	function automatic void clear_parse();
		term_at = TERM_PLACE;
		term_len = '0;
		gap_open = 1;
		rank_n = 0;
		file_n = 0;
		sq_n = 0;
		for (int i = 0; i < 8; i++) boards[i] = '0;
		black = 0;
		castle = '0;
		castle_seen = 0;
		lead_ch = '0;
		ep_sq = EP_NONE;
		clk_val = 0;
		half_val = 0;
		err = ERR_NONE;
	endfunction

	function automatic void flag(err_t code);
		if (err == ERR_NONE) err = code;
	endfunction

	function automatic void place_byte(logic [7:0] c);
		int          idx;
		int          sq;
		int          kind;
		bit          upper;
		logic [7:0]  low;
		logic [63:0] bit_mask;
		if (file_n == 8) begin
			if (c != CH_SLASH) begin
				flag(ERR_RANK_LONG);
				return;
			end
			file_n = 0;
			rank_n++;
		end else if (c >= CH_0 && c < CH_9) begin
			file_n += c - CH_0;
			sq_n += c - CH_0;
		end else begin
			idx = sq_n & 63;
			sq = 8 * (7 - (idx >> 3)) + (idx & 7);
			bit_mask = 64'd1 << sq;
			upper = (c >= CH_UA && c <= CH_UZ);
			low = upper ? c + 8'd32 : c;
			case (low)
				CH_P: kind = 0;
				CH_N: kind = 1;
				CH_B: kind = 2;
				CH_R: kind = 3;
				CH_Q: kind = 4;
				CH_K: kind = 5;
				default: begin
					flag(ERR_PIECE);
					return;
				end
			endcase
			boards[kind] |= bit_mask;
			boards[upper ? 6 : 7] |= bit_mask;
			file_n++;
			sq_n++;
		end
		if (file_n > 8) begin
			flag(ERR_RANK_LONG);
			return;
		end
		if (rank_n > 7) flag(ERR_RANKS);
	endfunction

	function automatic void castle_byte(logic [7:0] c, int p);
		if (p >= 4) begin
			flag(ERR_CASTLE_LONG);
			return;
		end
		if (p == 0 && c == CH_DASH) return;
		if (p == 1 && lead_ch == CH_DASH) begin
			flag(ERR_CASTLE_CHAR);
			return;
		end
		if (c == CH_UK) begin
			if (castle_seen == 1) flag(ERR_K_TWICE);
			else if (castle_seen > 1) flag(ERR_K_LATE);
			else begin
				castle[0] = 1;
				castle_seen = 1;
			end
		end else if (c == CH_UQ) begin
			if (castle_seen == 2) flag(ERR_Q_TWICE);
			else if (castle_seen > 2) flag(ERR_Q_LATE);
			else begin
				castle[1] = 1;
				castle_seen = 2;
			end
		end else if (c == CH_K) begin
			if (castle_seen == 3) flag(ERR_LK_TWICE);
			else if (castle_seen > 3) flag(ERR_LK_LATE);
			else begin
				castle[2] = 1;
				castle_seen = 3;
			end
		end else if (c == CH_Q) begin
			if (castle_seen == 4) flag(ERR_LQ_TWICE);
			else begin
				castle[3] = 1;
				castle_seen = 4;
			end
		end else begin
			flag(ERR_CASTLE_CHAR);
		end
	endfunction

	function automatic void close_term();
		case (term_at)
			TERM_PLACE: if (rank_n < 7 || file_n < 8) flag(ERR_BOARD);
			TERM_TURN: begin
				if (term_len > 1) flag(ERR_TURN_LONG);
				else if (lead_ch == CH_W) black = 0;
				else if (lead_ch == CH_B) black = 1;
				else if (lead_ch == CH_UB || lead_ch == CH_UW) flag(ERR_TURN_UPPER);
				else flag(ERR_TURN_CHAR);
			end
			TERM_EP: begin
				if (term_len == 1) begin
					if (lead_ch == CH_DASH) ep_sq = EP_NONE;
					else flag(ERR_EP);
				end
			end
			TERM_HALF, TERM_FULL: begin
				if (clk_val >= CLOCK_SAT) flag(ERR_CLOCK_BIG);
				else if (term_at == TERM_HALF) begin
					half_val = clk_val;
					clk_val = 0;
				end
			end
			default: ;
		endcase
		if (term_at != TERM_DONE) term_at = term_t'(term_at + 1);
		gap_open = 1;
	endfunction

	function automatic void term_byte(logic [7:0] c);
		int p;
		if (gap_open) begin
			gap_open = 0;
			term_len = '0;
			if (term_at == TERM_DONE) begin
				flag(ERR_TERMS);
				return;
			end
		end
		p = term_len;
		if (term_len < 7) term_len++;
		if (p == 0) lead_ch = c;
		case (term_at)
			TERM_PLACE: place_byte(c);
			TERM_CASTLE: castle_byte(c, p);
			TERM_EP: begin
				if (p == 1) begin
					if (lead_ch >= CH_A && lead_ch <= CH_H && c >= CH_1 && c <= CH_8)
						ep_sq = 7'((lead_ch - CH_A) + (c - CH_1) * 8);
					else flag(ERR_EP);
				end else if (p >= 2) begin
					flag(ERR_EP);
				end
			end
			TERM_HALF, TERM_FULL: begin
				if (c < CH_0 || c > CH_9) flag(ERR_CLOCK_CHAR);
				else begin
					clk_val = clk_val * 10 + (c - CH_0);
					if (clk_val > CLOCK_SAT) clk_val = CLOCK_SAT;
				end
			end
			default: ;
		endcase
	endfunction

	// returns 1 when the byte ends a string and fills the predicted result
	function automatic bit parse_byte(logic [7:0] c, output result_t r);
		r = '0;
		if (c != CH_NUL) begin
			if (err != ERR_NONE) return 0;
			if (c == CH_SP) begin
				if (!gap_open) close_term();
			end else begin
				term_byte(c);
			end
			return 0;
		end
		if (err == ERR_NONE && !gap_open) close_term();
		if (err == ERR_NONE && term_at != TERM_DONE) flag(missing_code(term_at));
		if (err == ERR_NONE) begin
			r.pawns = boards[0];
			r.knights = boards[1];
			r.bishops = boards[2];
			r.rooks = boards[3];
			r.queens = boards[4];
			r.kings = boards[5];
			r.white_men = boards[6];
			r.black_men = boards[7];
			r.side_info = {ep_sq, castle, black};
			r.move_clocks = {clk_val[15:0], half_val[15:0]};
		end
		r.status = err;
		clear_parse();
		return 1;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		clear_parse();
	end

	always @(posedge clk) begin
		result_t r;
		result_t exp_r;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (want_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result word %h", out_ch.data);
				end else begin
					exp_r = want_q.pop_front();
					r = out_ch.data;
					if (r.pawns !== exp_r.pawns || r.knights !== exp_r.knights ||
					    r.bishops !== exp_r.bishops || r.rooks !== exp_r.rooks ||
					    r.queens !== exp_r.queens || r.kings !== exp_r.kings ||
					    r.white_men !== exp_r.white_men || r.black_men !== exp_r.black_men ||
					    r.side_info !== exp_r.side_info ||
					    r.move_clocks !== exp_r.move_clocks || r.status !== exp_r.status) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch status exp %0d got %0d side exp %h got %h",
								exp_r.status, r.status, exp_r.side_info, r.side_info);
							$display("  clocks exp %h got %h", exp_r.move_clocks, r.move_clocks);
							$display("  boards exp %h %h %h %h %h %h %h %h", exp_r.pawns,
								exp_r.knights, exp_r.bishops, exp_r.rooks, exp_r.queens,
								exp_r.kings, exp_r.white_men, exp_r.black_men);
							$display("  boards got %h %h %h %h %h %h %h %h", r.pawns,
								r.knights, r.bishops, r.rooks, r.queens, r.kings,
								r.white_men, r.black_men);
						end
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (parse_byte(in_ch.data.ch, exp_r)) want_q.push_back(exp_r);
			end
			pending = want_q.size();
		end
	end
endmodule

@@ tb/testbench.sv @@
// testbench top: fen byte stimulus, result receiver and verdict
module testbench;
	import frp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycles;
	int   sent;
	int   strings;
	bit   rx_hold;
	bit   idle_on;
	logic [7:0] fen_q[$];

	frp_in_if  in_ch();
	frp_out_if out_ch();

	fen_record_parser dut (.clk(clk), .arst_n(arst_n), .byte_in(in_ch), .res_out(out_ch));
	frp_checker chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.errors(errors), .pending(pending));

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data.ch <= b;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	// sends the queued bytes and a terminator
	task automatic send_fen();
		foreach (fen_q[i]) send_byte(fen_q[i]);
		send_byte(CH_NUL);
		fen_q.delete();
		strings++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) fen_q.push_back(s[i]);
		send_fen();
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) fen_q.push_back(s[i]);
	endtask

	task automatic push_sep();
		int n;
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
		repeat (n) fen_q.push_back(CH_SP);
	endtask

	// stops offering and waits until every predicted result has come back
	task automatic drain();
		in_ch.valid <= 0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	function automatic int pick_clock();
		case ($urandom_range(0, 7))
			0: return $urandom_range(65530, 65540);
			1: return $urandom_range(0, 999999);
			2: return 0;
			default: return $urandom_range(0, 300);
		endcase
	endfunction

	task automatic build_fen();
		string men;
		int    filled;
		int    n;
		bit    any;
		men = "pnbrqkPNBRQK";
		if ($urandom_range(0, 5) == 0) push_sep();
		for (int r = 0; r < 8; r++) begin
			filled = 0;
			while (filled < 8) begin
				if ($urandom_range(0, 2) == 0) begin
					n = $urandom_range(1, 8 - filled);
					fen_q.push_back(8'(CH_0 + n));
					filled += n;
				end else begin
					fen_q.push_back(men[$urandom_range(0, 11)]);
					filled++;
				end
			end
			if (r < 7) fen_q.push_back(CH_SLASH);
		end
		push_sep();
		fen_q.push_back($urandom_range(0, 1) ? CH_W : CH_B);
		push_sep();
		any = 0;
		if ($urandom_range(0, 3) != 0) begin
			if ($urandom_range(0, 1)) begin fen_q.push_back(CH_UK); any = 1; end
			if ($urandom_range(0, 1)) begin fen_q.push_back(CH_UQ); any = 1; end
			if ($urandom_range(0, 1)) begin fen_q.push_back(CH_K); any = 1; end
			if ($urandom_range(0, 1)) begin fen_q.push_back(CH_Q); any = 1; end
		end
		if (!any) fen_q.push_back(CH_DASH);
		push_sep();
		if ($urandom_range(0, 1)) fen_q.push_back(CH_DASH);
		else begin
			fen_q.push_back(8'(CH_A + $urandom_range(0, 7)));
			fen_q.push_back(8'(CH_1 + $urandom_range(0, 7)));
		end
		push_sep();
		push_text($sformatf("%0d", pick_clock()));
		push_sep();
		push_text($sformatf("%0d", pick_clock()));
		if ($urandom_range(0, 5) == 0) push_sep();
	endtask

	// half clean records, the rest damaged or pure noise
	task automatic random_fen();
		int mode;
		int pos;
		mode = $urandom_range(0, 11);
		if (mode == 11) begin
			repeat ($urandom_range(1, 20)) fen_q.push_back(8'($urandom_range(1, 255)));
		end else begin
			build_fen();
			pos = $urandom_range(0, fen_q.size() - 1);
			case (mode)
				6, 7: fen_q[pos] = 8'($urandom_range(1, 255));
				8: while (fen_q.size() > pos) void'(fen_q.pop_back());
				9: fen_q.insert(pos, fen_q[pos]);
				10: begin
					push_sep();
					fen_q.push_back(8'($urandom_range(33, 126)));
				end
				default: ;
			endcase
		end
		send_fen();
	endtask

	initial begin
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				out_ch.ready <= 0;
				repeat (400) @(posedge clk);
				rx_hold = 0;
			end
			repeat (idle_on ? $urandom_range(0, 3) : 0) begin
				out_ch.ready <= 0;
				@(posedge clk);
			end
			out_ch.ready <= 1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		sent = 0;
		strings = 0;
		cycles = 0;
		rx_hold = 0;
		idle_on = 1;
		@(posedge arst_n);
		@(posedge clk);
		send_text("rnbqkbnr/pppppppp/8/8/8/8/PPPPPPPP/RNBQKBNR w KQkq - 0 1");
		send_text("");
		send_text("   ");
		send_text("8/8/8/8/8/8/8/7K b - e3 65534 65535");
		send_text("8/8/8/8/8/8/8/9 w - - 0 1");
		send_text("8/8/8/8/8/8/8/8/8 w - - 0 1");
		send_text("8/8/8/8/8/8/8/8 W KK - 0 1");
		send_text("8/8/8/8/8/8/8/8 w -K h9 0 1 x");
		send_text("8/8/8/8/8/8/8/8\tw - - 0 1");
		send_text("8/8/8/8/8/8/8/8 w qk - 0");
		send_text("0pP7/8/8/8/8/8/8/8 w - - 12a 1");
		drain();
		repeat (5) @(posedge clk);
		// long receiver stall while short strings pile up
		rx_hold = 1;
		repeat (8) send_text("x");
		while (sent < 900) random_fen();
		// quiet phase with no idling on either side
		drain();
		repeat (5) @(posedge clk);
		idle_on = 0;
		repeat (15) random_fen();
		idle_on = 1;
		while (sent < 1450 || strings < 60) random_fen();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
